// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent checks with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/nlv_pkg.sv =====
// ---------------------------------------------------------------------------
// nlv_pkg
// Field widths, packing offsets and codes of the nearest label voxel search.
// ---------------------------------------------------------------------------
package nlv_pkg;

  localparam int LABEL_W     = 16;
  localparam int COORD_W     = 5;
  localparam int DIM_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  // s_tdata packing
  localparam int X_LSB  = 0;
  localparam int Y_LSB  = X_LSB + COORD_W;
  localparam int Z_LSB  = Y_LSB + COORD_W;
  localparam int WL_LSB = Z_LSB + COORD_W;

  // request kinds (s_tuser)
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

endpackage

// ===== sv/nlv_ram.sv =====
// ---------------------------------------------------------------------------
// nlv_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ---------------------------------------------------------------------------
module nlv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/nearest_label_voxel_search_core.sv =====
// Write request: taken back to back, no result.
// Query: when the center voxel decides it, ST_CENTER and then ST_DONE register the result,
//   else ST_SCAN reads the (2*SEARCH_RADIUS+1)^3 cube first; one label RAM read per cycle.
// A new request is taken only between queries; a held result stalls only a query in ST_DONE.
// Reset: synchronous; then a clearing pass zeroes the GRID_SIDE^3 (32768 by default)
//   label RAM words while s_tready stays low; register writes are taken as ever.
// ---------------------------------------------------------------------------
// nearest_label_voxel_search_core
// Voxel label store with nearest nonzero label search in a cube around a voxel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_label_voxel_search_core #(
  parameter int GRID_SIDE     = 32,
  parameter int SEARCH_RADIUS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  // register write port
  input  logic                              cfg_we,
  input  logic [nlv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nlv_pkg::DIM_W-1:0]         cfg_data,
  // request side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [4:0] coord_x, [9:5] coord_y, [14:10] coord_z, [30:15] write_label, [31] zero
  input  logic [nlv_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [0] action
  input  logic                              s_tuser,
  // result side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] found_label
  output logic [nlv_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // [0] found
  output logic                              m_tuser
);

  import nlv_pkg::*;

  localparam int DEPTH  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  // offset width: signed, holds -R..R
  localparam int OW     = $clog2(SEARCH_RADIUS + 1) + 1;
  // neighbor coordinate width: signed, holds -R..31+R and any dimension
  localparam int NCW    = COORD_W + 2 + $clog2(SEARCH_RADIUS + 1);
  // squared distance width
  localparam int DW     = $clog2(3 * SEARCH_RADIUS * SEARCH_RADIUS + 1);

  localparam logic signed [OW-1:0] OFF_MAX = OW'(SEARCH_RADIUS);
  localparam logic signed [OW-1:0] OFF_MIN = -OFF_MAX;

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CENTER = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // -------------------------------------------------------------------------
  // helpers
  // -------------------------------------------------------------------------
  function automatic logic signed [NCW-1:0] zext_coord(input logic [COORD_W-1:0] c);
    return $signed({{(NCW-COORD_W){1'b0}}, c});
  endfunction

  function automatic logic signed [NCW-1:0] sext_off(input logic signed [OW-1:0] o);
    return $signed({{(NCW-OW){o[OW-1]}}, o});
  endfunction

  function automatic logic in_grid(
    input logic signed [NCW-1:0] x,
    input logic signed [NCW-1:0] y,
    input logic signed [NCW-1:0] z,
    input logic [DIM_W-1:0]      ex,
    input logic [DIM_W-1:0]      ey,
    input logic [DIM_W-1:0]      ez
  );
    logic signed [NCW-1:0] sx, sy, sz;
    sx = $signed({{(NCW-DIM_W){1'b0}}, ex});
    sy = $signed({{(NCW-DIM_W){1'b0}}, ey});
    sz = $signed({{(NCW-DIM_W){1'b0}}, ez});
    return (x >= 0) && (y >= 0) && (z >= 0) && (x < sx) && (y < sy) && (z < sz);
  endfunction

  // linear voxel address; only used for in-grid, nonnegative coordinates
  function automatic logic [ADDR_W-1:0] lin_addr(
    input logic signed [NCW-1:0] x,
    input logic signed [NCW-1:0] y,
    input logic signed [NCW-1:0] z
  );
    logic [31:0] ux, uy, uz, a;
    ux = 32'($unsigned(x));
    uy = 32'($unsigned(y));
    uz = 32'($unsigned(z));
    a  = ux + 32'(GRID_SIDE) * (uy + 32'(GRID_SIDE) * uz);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [2*OW-1:0] sq(input logic signed [OW-1:0] o);
    logic signed [2*OW-1:0] e;
    e = {{OW{o[OW-1]}}, o};
    return $unsigned(e * e);
  endfunction

  // -------------------------------------------------------------------------
  // registers
  // -------------------------------------------------------------------------
  logic [DIM_W-1:0]         dim_x, dim_y, dim_z;
  logic [DIM_W-1:0]         eff_x, eff_y, eff_z;
  logic [2:0]               state;
  logic [ADDR_W-1:0]        clr_addr;

  logic signed [NCW-1:0]    q_x, q_y, q_z;     // queried voxel
  logic                     q_in;              // queried voxel inside the grid
  logic signed [OW-1:0]     off_x, off_y, off_z;

  logic                     pipe_v;            // a RAM read is in flight this cycle
  logic [DW-1:0]            pipe_d;            // its squared distance
  logic                     best_hit;
  logic [DW-1:0]            best_d;
  logic [LABEL_W-1:0]       res_label;

  // -------------------------------------------------------------------------
  // register write port
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x <= DIM_RESET;
      dim_y <= DIM_RESET;
      dim_z <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIM_X: dim_x <= cfg_data;
        CFG_DIM_Y: dim_y <= cfg_data;
        CFG_DIM_Z: dim_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // dimensions above GRID_SIDE act as GRID_SIDE; result never exceeds the register
  assign eff_x = (32'(dim_x) > 32'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : dim_x;
  assign eff_y = (32'(dim_y) > 32'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : dim_y;
  assign eff_z = (32'(dim_z) > 32'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : dim_z;

  // -------------------------------------------------------------------------
  // request decode
  // -------------------------------------------------------------------------
  logic                  in_acc;
  logic signed [NCW-1:0] in_x, in_y, in_z;
  logic                  in_v;
  logic [LABEL_W-1:0]    in_label;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_x     = zext_coord(s_tdata[X_LSB +: COORD_W]);
  assign in_y     = zext_coord(s_tdata[Y_LSB +: COORD_W]);
  assign in_z     = zext_coord(s_tdata[Z_LSB +: COORD_W]);
  assign in_label = s_tdata[WL_LSB +: LABEL_W];
  assign in_v     = in_grid(in_x, in_y, in_z, eff_x, eff_y, eff_z);

  // -------------------------------------------------------------------------
  // scan position: neighbor of the queried voxel at the current offset
  // -------------------------------------------------------------------------
  logic signed [NCW-1:0] n_x, n_y, n_z;
  logic                  n_v;
  logic [DW-1:0]         n_d;
  logic                  scan_last;

  assign n_x = q_x + sext_off(off_x);
  assign n_y = q_y + sext_off(off_y);
  assign n_z = q_z + sext_off(off_z);
  assign n_v = in_grid(n_x, n_y, n_z, eff_x, eff_y, eff_z);
  assign n_d = DW'(sq(off_x)) + DW'(sq(off_y)) + DW'(sq(off_z));
  assign scan_last = (off_x == OFF_MAX) && (off_y == OFF_MAX) && (off_z == OFF_MAX);

  // -------------------------------------------------------------------------
  // label RAM
  // -------------------------------------------------------------------------
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [LABEL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [LABEL_W-1:0] ram_rdata;

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      // writes outside the grid are dropped
      ram_we    = in_acc && (s_tuser == ACT_WRITE) && in_v;
      ram_waddr = lin_addr(in_x, in_y, in_z);
      ram_wdata = in_label;
    end
    // idle: center voxel of a possible query; scan: current neighbor
    if (state == ST_SCAN) begin
      ram_raddr = n_v ? lin_addr(n_x, n_y, n_z) : '0;
    end else begin
      ram_raddr = in_v ? lin_addr(in_x, in_y, in_z) : '0;
    end
  end

  nlv_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (DEPTH)
  ) u_labels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the read that returns now improves on the best so far; strict less keeps
  // the first voxel in scan order on a tie
  logic take;
  assign take = pipe_v && (ram_rdata != '0) && (!best_hit || (pipe_d < best_d));

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pipe_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // in ST_DONE the output register is reloaded instead
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          // center read was issued in this cycle
          if (in_acc && (s_tuser == ACT_QUERY)) begin
            q_x   <= in_x;
            q_y   <= in_y;
            q_z   <= in_z;
            q_in  <= in_v;
            state <= ST_CENTER;
          end
        end
        ST_CENTER: begin
          res_label <= q_in ? ram_rdata : '0;
          best_hit  <= q_in && (ram_rdata != '0);
          off_x     <= OFF_MIN;
          off_y     <= OFF_MIN;
          off_z     <= OFF_MIN;
          if (q_in && (ram_rdata == '0)) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SCAN: begin
          pipe_v <= n_v;
          pipe_d <= n_d;
          if (take) begin
            best_hit  <= 1'b1;
            best_d    <= pipe_d;
            res_label <= ram_rdata;
          end
          // x fastest, then y, then z
          if (off_x != OFF_MAX) begin
            off_x <= off_x + 1'b1;
          end else begin
            off_x <= OFF_MIN;
            if (off_y != OFF_MAX) begin
              off_y <= off_y + 1'b1;
            end else begin
              off_y <= OFF_MIN;
              off_z <= off_z + 1'b1;
            end
          end
          if (scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pipe_v <= 1'b0;
          if (take) begin
            best_hit  <= 1'b1;
            best_d    <= pipe_d;
            res_label <= ram_rdata;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          // wait for the output register to free up
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_label;
            m_tuser  <= best_hit;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------
  `ASSERT_SAME(a_no_req_in_clear, clk, rst, state == ST_CLEAR, !s_tready)
  `ASSERT_SAME(a_found_matches_label, clk, rst, m_tvalid, (m_tdata != '0) == m_tuser)
  `ASSERT_NEXT(a_query_starts, clk, rst, in_acc && (s_tuser == ACT_QUERY), state == ST_CENTER)
  `ASSERT_SAME(a_pipe_in_scan, clk, rst, pipe_v, (state == ST_SCAN) || (state == ST_DRAIN))
  `ASSERT_SAME(a_ram_wr_state, clk, rst, ram_we, (state == ST_CLEAR) || (state == ST_IDLE))

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_label_voxel_search_core: a queue-fed
// driver offers write and query requests, an in-bench shadow of the label
// store predicts each query result, and a monitor compares the result
// stream field by field against the queued predictions.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nlv_pkg::*;

  localparam int GRID_SIDE     = 32;
  localparam int SEARCH_RADIUS = 3;
  localparam int GRID_CELLS    = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int LONG_HOLD     = 2000;  // receiver hold-off, in cycles
  localparam int SETTLE_CYCLES = 8;     // lets the last accepted write land before the next step
  localparam int TAIL_CYCLES   = 400;   // longer than the slowest query

  typedef struct packed {
    logic                action;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [LABEL_W-1:0]  label;
  } voxel_req_t;

  typedef struct packed {
    logic [LABEL_W-1:0]  label;
    logic                found;
  } search_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_DIM_X;
  logic [DIM_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = ACT_WRITE;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  nearest_label_voxel_search_core #(
    .GRID_SIDE     (GRID_SIDE),
    .SEARCH_RADIUS (SEARCH_RADIUS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Shadow state: label store and dimension registers as the block sees them
  // -------------------------------------------------------------------------
  bit [LABEL_W-1:0] shadow_labels [GRID_CELLS];
  bit [DIM_W-1:0]   dim_x = DIM_RESET;
  bit [DIM_W-1:0]   dim_y = DIM_RESET;
  bit [DIM_W-1:0]   dim_z = DIM_RESET;

  voxel_req_t     request_backlog [$];  // requests not yet offered
  search_result_t search_results [$];   // predicted query results, oldest first
  voxel_req_t     active_req;           // request currently on s_tdata
  int             error_count = 0;
  bit             steady_flow = 1'b0;   // both sides stop idling while set
  bit             hold_off_req = 1'b0;  // asks the receiver for a long hold-off
  bit             hold_done = 1'b0;     // the long hold-off has been started
  int             hold_left = 0;

  // register values above the grid side saturate
  function automatic int eff_dim(bit [DIM_W-1:0] d);
    return (d > GRID_SIDE) ? GRID_SIDE : int'(d);
  endfunction

  function automatic bit in_bounds(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 &&
           x < eff_dim(dim_x) && y < eff_dim(dim_y) && z < eff_dim(dim_z);
  endfunction

  function automatic int voxel_addr(int x, int y, int z);
    return x + GRID_SIDE * (y + GRID_SIDE * z);
  endfunction

  // Center label if nonzero, else the nearest nonzero label in the cube.
  // Strict less-than keeps the first voxel in z,y,x scan order on a tie.
  function automatic search_result_t search_nearest_label(int cx, int cy, int cz);
    search_result_t res;
    int best_dist;
    int sq_dist;
    bit [LABEL_W-1:0] lbl;
    res.label = '0;
    res.found = 1'b0;
    best_dist = 1 << 30;
    if (!in_bounds(cx, cy, cz)) return res;
    res.label = shadow_labels[voxel_addr(cx, cy, cz)];
    if (res.label == '0) begin
      for (int dz = -SEARCH_RADIUS; dz <= SEARCH_RADIUS; dz++)
        for (int dy = -SEARCH_RADIUS; dy <= SEARCH_RADIUS; dy++)
          for (int dx = -SEARCH_RADIUS; dx <= SEARCH_RADIUS; dx++) begin
            if (in_bounds(cx + dx, cy + dy, cz + dz)) begin
              lbl = shadow_labels[voxel_addr(cx + dx, cy + dy, cz + dz)];
              sq_dist = dx * dx + dy * dy + dz * dz;
              if (lbl != '0 && sq_dist < best_dist) begin
                best_dist = sq_dist;
                res.label = lbl;
              end
            end
          end
    end
    res.found = (res.label != '0);
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Request driver: offers backlog entries, updates the shadow on acceptance
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    voxel_req_t            nxt;
    logic [IN_TDATA_W-1:0] word;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (active_req.action == ACT_WRITE) begin
          // writes outside the dimensions are dropped
          if (in_bounds(active_req.x, active_req.y, active_req.z))
            shadow_labels[voxel_addr(active_req.x, active_req.y, active_req.z)] =
              active_req.label;
        end else begin
          search_results = {search_results,
            search_nearest_label(active_req.x, active_req.y, active_req.z)};
        end
      end
      // valid is only dropped after a handshake, never withdrawn
      if (!s_tvalid || s_tready) begin
        if (request_backlog.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= 30)) begin
          nxt  = request_backlog.pop_front();
          word = '0;
          word[X_LSB +: COORD_W]  = nxt.x;
          word[Y_LSB +: COORD_W]  = nxt.y;
          word[Z_LSB +: COORD_W]  = nxt.z;
          word[WL_LSB +: LABEL_W] = nxt.label;
          s_tvalid   <= 1'b1;
          s_tdata    <= word;
          s_tuser    <= nxt.action;
          active_req <= nxt;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result receiver: random back-pressure plus one long hold-off on request
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_off_req && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= steady_flow || $urandom_range(0, 99) >= 30;
    end
  end

  // -------------------------------------------------------------------------
  // Result monitor
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    search_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (search_results.size() == 0) begin
        $error("unexpected result: found_label %h found %b", m_tdata, m_tuser);
        error_count++;
      end else begin
        want = search_results.pop_front();
        if (m_tdata !== want.label) begin
          $error("found_label: expected %h, actual %h", want.label, m_tdata);
          error_count++;
        end
        if (m_tuser !== want.found) begin
          $error("found: expected %b, actual %b", want.found, m_tuser);
          error_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic queue_write(int x, int y, int z, int label);
    voxel_req_t r;
    r.action = ACT_WRITE;
    r.x = COORD_W'(x); r.y = COORD_W'(y); r.z = COORD_W'(z);
    r.label = LABEL_W'(label);
    request_backlog = {request_backlog, r};
  endtask

  task automatic queue_query(int x, int y, int z);
    voxel_req_t r;
    r.action = ACT_QUERY;
    r.x = COORD_W'(x); r.y = COORD_W'(y); r.z = COORD_W'(z);
    r.label = LABEL_W'($urandom);  // ignored by a query, still toggles the bits
    request_backlog = {request_backlog, r};
  endtask

  // Block is idle here; the last write lands on the final edge with cfg_we high.
  task automatic set_dims(int dx, int dy, int dz);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_DIM_X; cfg_data <= DIM_W'(dx);
    @(posedge clk);
    cfg_index <= CFG_DIM_Y; cfg_data <= DIM_W'(dy);
    @(posedge clk);
    cfg_index <= CFG_DIM_Z; cfg_data <= DIM_W'(dz);
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_x = DIM_W'(dx);
    dim_y = DIM_W'(dy);
    dim_z = DIM_W'(dz);
  endtask

  // sender pause: everything offered, accepted and answered
  task automatic wait_quiet();
    while (request_backlog.size() != 0 || s_tvalid || search_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] jitter(int c);
    int v;
    v = c + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > GRID_SIDE - 1) v = GRID_SIDE - 1;
    return COORD_W'(v);
  endfunction

  // Requests clustered around a focus voxel so that searches mostly find
  // something off-center; some fully random noise mixed in. Focus moves now
  // and then. Coordinates may stray past the dimensions on purpose.
  task automatic queue_random(int count);
    int fx, fy, fz, ex, ey, ez;
    voxel_req_t r;
    ex = eff_dim(dim_x);
    ey = eff_dim(dim_y);
    ez = eff_dim(dim_z);
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        fx = $urandom_range(0, (ex > 0) ? ex - 1 : GRID_SIDE - 1);
        fy = $urandom_range(0, (ey > 0) ? ey - 1 : GRID_SIDE - 1);
        fz = $urandom_range(0, (ez > 0) ? ez - 1 : GRID_SIDE - 1);
      end
      r.action = ($urandom_range(0, 99) < 45) ? ACT_WRITE : ACT_QUERY;
      if ($urandom_range(0, 99) < 15) begin
        r.x = COORD_W'($urandom);
        r.y = COORD_W'($urandom);
        r.z = COORD_W'($urandom);
      end else begin
        r.x = jitter(fx);
        r.y = jitter(fy);
        r.z = jitter(fz);
      end
      r.label = ($urandom_range(0, 99) < 20) ? '0 : LABEL_W'($urandom);
      request_backlog = {request_backlog, r};
    end
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset dimensions (full grid); the clearing pass holds s_tready low
    queue_write(0, 0, 0, 16'hFFFF);
    queue_query(0, 0, 0);             // center decides
    queue_query(31, 31, 31);          // empty neighborhood at the far corner
    queue_write(31, 31, 31, 16'h0001);
    queue_query(28, 31, 31);          // hit at the cube edge
    queue_query(27, 31, 31);          // one step beyond the cube
    queue_write(10, 10, 10, 16'h1234);
    queue_write(10, 10, 12, 16'h5678);
    queue_write(10, 11, 11, 16'hAAAA);
    queue_query(10, 10, 11);          // three-way tie, first in scan order wins
    queue_write(17, 17, 17, 16'h0007);
    queue_write(20, 20, 22, 16'h0008);
    queue_query(20, 20, 20);          // nearer label found later in the scan
    queue_write(0, 0, 0, 16'h0000);   // erase
    queue_write(3, 3, 3, 16'h5555);
    queue_query(0, 0, 0);             // cube corner
    wait_quiet();

    // small grid: writes and queries past the dimensions
    set_dims(4, 5, 3);
    queue_query(4, 0, 0);
    queue_write(4, 1, 1, 16'h00FF);
    queue_query(3, 1, 1);
    queue_query(3, 4, 2);
    wait_quiet();

    // zero dimension: nothing is stored, nothing is found
    set_dims(0, 32, 32);
    queue_write(1, 1, 1, 16'h0F0F);
    queue_query(1, 1, 1);
    wait_quiet();

    // oversized registers saturate at the grid side
    set_dims(63, 33, 32);
    queue_query(31, 31, 31);
    queue_query(10, 10, 11);
    wait_quiet();

    // random part, a run with no idling first
    set_dims(32, 32, 32);
    steady_flow = 1'b1;
    queue_random(150);
    wait_quiet();
    steady_flow = 1'b0;

    set_dims(7, 9, 5);
    queue_random(130);
    wait_quiet();

    set_dims($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32));
    queue_random(130);
    wait_quiet();

    set_dims(1, 32, 2);
    queue_random(60);
    wait_quiet();

    set_dims(63, 33, 32);
    queue_random(130);
    wait_quiet();

    set_dims(1, 1, 1);
    queue_random(30);
    wait_quiet();

    set_dims(0, 12, 12);
    queue_random(30);
    wait_quiet();

    set_dims($urandom_range(0, 63), $urandom_range(1, 63), $urandom_range(1, 63));
    queue_random(130);
    wait_quiet();

    // back-pressure: receiver holds off while queries keep coming, so the
    // block fills and stalls its input
    set_dims(32, 32, 32);
    hold_off_req = 1'b1;
    for (int i = 0; i < 20; i++) queue_query(31, 31, 31);
    queue_random(20);
    wait_quiet();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
